>>> rtl/core/rcr_pkg.sv
// Shared definitions for the RAID parity check and repair block.
// Holds default sizes, the register index codes, the sequencer states and
// the check structs passed between the lanes, the merge stage and the top.
package rcr_pkg;

  localparam int DEF_MAX_DISKS       = 8;
  localparam int DEF_MAX_SECTOR_BITS = 32;

  typedef enum logic [1:0] {
    CFG_NUM_DISKS   = 2'd0,
    CFG_SECTOR_BITS = 2'd1,
    CFG_ODD_PARITY  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_PAD,
    ST_STATUS
  } state_e;

  // What one disk lane reports about its bit of the current column.
  typedef struct packed {
    logic miss;
    logic pbit;
  } lane_chk_t;

  // Column verdict from the merge stage.
  typedef struct packed {
    logic bad;
    logic repair;
  } chk_t;

endpackage

>>> rtl/core/rcr_lane.sv
// One disk lane: checks its bit of each column and keeps the disk's bits of
// the current block, shifting them out toward bit zero while the block drains.
// Depends on rcr_pkg.
module rcr_lane #(
  parameter int MAX_SECTOR_BITS = rcr_pkg::DEF_MAX_SECTOR_BITS
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                col_bit_i,
  input  logic                miss_bit_i,
  output rcr_pkg::lane_chk_t  chk_o,
  input  logic                repair_i,
  input  logic                wr_en_i,
  input  logic [$clog2(MAX_SECTOR_BITS > 1 ? MAX_SECTOR_BITS : 2)-1:0] wr_idx_i,
  input  logic                shift_en_i,
  input  logic [2:0]          shift_amt_i,
  output logic [3:0]          nib_o
);
  import rcr_pkg::*;

  logic [MAX_SECTOR_BITS-1:0] sec_q;
  logic [MAX_SECTOR_BITS+3:0] ext_w;
  logic                       wr_bit_w;

  assign chk_o.miss = en_i & miss_bit_i;
  assign chk_o.pbit = en_i & ~miss_bit_i & col_bit_i;

  // A missing bit is stored as the rebuilt value, or as zero when it cannot be rebuilt.
  assign wr_bit_w = chk_o.pbit | (chk_o.miss & repair_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      sec_q[wr_idx_i] <= wr_bit_w;
    end else if (shift_en_i) begin
      sec_q <= sec_q >> shift_amt_i;
    end
  end

  assign ext_w = {4'b0000, sec_q};
  assign nib_o = ext_w[3:0];

endmodule

>>> rtl/core/rcr_merge.sv
// Merge stage: combines the lane reports of one column into a verdict.
// Depends on rcr_pkg.
module rcr_merge #(
  parameter int MAX_DISKS = rcr_pkg::DEF_MAX_DISKS
) (
  input  rcr_pkg::lane_chk_t [MAX_DISKS-1:0] lanes_i,
  input  logic                               odd_i,
  output rcr_pkg::chk_t                      chk_o
);
  import rcr_pkg::*;

  logic       par;
  logic [1:0] nmiss;

  always_comb begin
    par   = odd_i;
    nmiss = 2'd0;
    for (int j = 0; j < MAX_DISKS; j++) begin
      par = par ^ lanes_i[j].pbit;
      if (lanes_i[j].miss && nmiss != 2'd2) begin
        nmiss = nmiss + 2'd1;
      end
    end
    chk_o.bad    = (nmiss == 2'd2) || ((nmiss == 2'd0) && par);
    chk_o.repair = (nmiss == 2'd1) && par;
  end

endmodule

>>> rtl/core/raid_parity_check_repair.sv
// RAID parity check and repair: top level with the disk lanes, the merge stage
// and the drain sequencer. Depends on rcr_pkg, rcr_lane and rcr_merge.
// Columns that do not end a block are taken one per cycle while the sequencer idles. A block end
// drains in nibble steps, plus up to one step per disk boundary; each digit is presented in the
// cycle after its step and output stalls hold the drain. Set end adds a pad word when bits are
// left over, then a status word. Reset clears control state but not the per-disk block bits.
module raid_parity_check_repair #(
  parameter int MAX_DISKS       = rcr_pkg::DEF_MAX_DISKS,
  parameter int MAX_SECTOR_BITS = rcr_pkg::DEF_MAX_SECTOR_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [5:0]           cfg_data_i,
  // Column input channel.
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [MAX_DISKS-1:0] column_bits_i,
  input  logic [MAX_DISKS-1:0] missing_mask_i,
  input  logic                 block_end_i,
  input  logic                 set_end_i,
  // Result output channel.
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [3:0]           hex_digit_o,
  output logic                 is_status_o,
  output logic                 set_valid_o,
  output logic                 last_o
);
  import rcr_pkg::*;

  // Column counter holds 0..MAX_SECTOR_BITS; store index covers the depth only.
  localparam int CW = $clog2(MAX_SECTOR_BITS + 1);
  localparam int IW = $clog2(MAX_SECTOR_BITS > 1 ? MAX_SECTOR_BITS : 2);
  localparam int DW = $clog2(MAX_DISKS);
  localparam int TW = $clog2(MAX_DISKS * MAX_SECTOR_BITS + 1);

  // Configuration registers.
  logic [3:0] ndisk_q;
  logic [5:0] sbits_q;
  logic       odd_q;

  // Stream state.
  state_e          state_q, state_d;
  logic [CW-1:0]   cc_q, cc_d;
  logic [DW-1:0]   par_q, par_d;
  logic [2:0]      acc_q, acc_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            valid_q, valid_d;

  // Drain bookkeeping for the block being emitted.
  logic [DW-1:0]   disk_q, disk_d;
  logic [DW-1:0]   pd_q, pd_d;
  logic [CW-1:0]   n_q, n_d;
  logic [CW-1:0]   rem_q, rem_d;
  logic [TW-1:0]   total_q, total_d;
  logic            setend_q, setend_d;

  // Output register.
  logic            ovalid_q, ovalid_d;
  logic [3:0]      ohex_q, ohex_d;
  logic            ostat_q, ostat_d;
  logic            osetv_q, osetv_d;
  logic            olast_q, olast_d;

  logic [3:0]      d_eff;
  logic [CW-1:0]   s_eff;
  logic            in_acc;
  logic            out_free;
  logic [CW-1:0]   n_new;
  logic            ends;
  logic [3:0]      pd_w;
  logic [DW-1:0]   first_w;
  logic [3+CW:0]   prod_w;
  logic [2:0]      need_w;
  logic [2:0]      t_w;
  logic [3:0]      a_w;
  logic [2:0]      csum_w;
  logic [CW-1:0]   rem_next;
  logic [TW-1:0]   total_next;
  logic [DW-1:0]   nd_w;
  logic [3:0]      pdx_w;
  logic            step_w;

  lane_chk_t [MAX_DISKS-1:0] lane_chk_w;
  chk_t                      chk_w;
  logic [3:0]                nib_w [MAX_DISKS];

  // Effective geometry: out-of-range disk counts clamp to the nearest legal value, sector sizes to the maximum.
  always_comb begin
    if (ndisk_q < 4'd2) begin
      d_eff = 4'd2;
    end else if (ndisk_q > 4'(MAX_DISKS)) begin
      d_eff = 4'(MAX_DISKS);
    end else begin
      d_eff = ndisk_q;
    end
    if (sbits_q == 6'd0 || 32'(sbits_q) > 32'(MAX_SECTOR_BITS)) begin
      s_eff = CW'(MAX_SECTOR_BITS);
    end else begin
      s_eff = CW'(sbits_q);
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !ovalid_q || !out_stall_i;
  assign step_w     = (state_q == ST_DRAIN) && out_free;

  // One lane per disk. Each checks its bit and keeps its column bits of the block.
  for (genvar j = 0; j < MAX_DISKS; j++) begin : g_lane
    rcr_lane #(
      .MAX_SECTOR_BITS(MAX_SECTOR_BITS)
    ) u_lane (
      .clk_i       (clk_i),
      .en_i        (4'(j) < d_eff),
      .col_bit_i   (column_bits_i[j]),
      .miss_bit_i  (missing_mask_i[j]),
      .chk_o       (lane_chk_w[j]),
      .repair_i    (chk_w.repair),
      .wr_en_i     (in_acc),
      .wr_idx_i    (cc_q[IW-1:0]),
      .shift_en_i  (step_w && (disk_q == DW'(j))),
      .shift_amt_i (t_w),
      .nib_o       (nib_w[j])
    );
  end

  rcr_merge #(
    .MAX_DISKS(MAX_DISKS)
  ) u_merge (
    .lanes_i (lane_chk_w),
    .odd_i   (odd_q),
    .chk_o   (chk_w)
  );

  // Block geometry at the accepting column.
  always_comb begin
    n_new = cc_q + 1'b1;
    ends  = block_end_i || set_end_i || (n_new >= s_eff);
    // The stored parity index may exceed a smaller disk count after a reconfiguration.
    pd_w = 4'(par_q);
    for (int i = 0; i < 4; i++) begin
      if (pd_w >= d_eff) begin
        pd_w = pd_w - d_eff;
      end
    end
    first_w = (pd_w == 4'd0) ? DW'(1) : DW'(0);
    prod_w  = {{CW{1'b0}}, d_eff - 4'd1} * {4'd0, n_new};
  end

  // One nibble step: take as many bits from the current disk as the nibble still needs, or as the disk has left.
  always_comb begin
    need_w = 3'd4 - 3'(cnt_q);
    t_w    = (32'(rem_q) < 32'(need_w)) ? 3'(rem_q) : need_w;
    a_w    = {1'b0, acc_q};
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < t_w) begin
        a_w = {a_w[2:0], nib_w[disk_q][i]};
      end
    end
    csum_w     = 3'(cnt_q) + t_w;
    rem_next   = rem_q - CW'(t_w);
    total_next = total_q - TW'(t_w);
    nd_w       = disk_q + 1'b1;
    if (nd_w == pd_q) begin
      nd_w = nd_w + 1'b1;
    end
    pdx_w = 4'(pd_q) + 4'd1;
  end

  // Sequencer: accepts columns in idle, then drains; at a set end it pads if bits are left over and reports status.
  always_comb begin
    state_d  = state_q;
    cc_d     = cc_q;
    par_d    = par_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    valid_d  = valid_q;
    disk_d   = disk_q;
    pd_d     = pd_q;
    n_d      = n_q;
    rem_d    = rem_q;
    total_d  = total_q;
    setend_d = setend_q;
    ovalid_d = ovalid_q;
    ohex_d   = ohex_q;
    ostat_d  = ostat_q;
    osetv_d  = osetv_q;
    olast_d  = olast_q;

    if (!out_stall_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          valid_d = valid_q & ~chk_w.bad;
          if (ends) begin
            cc_d     = '0;
            pd_d     = DW'(pd_w);
            disk_d   = first_w;
            n_d      = n_new;
            rem_d    = n_new;
            total_d  = TW'(prod_w);
            setend_d = set_end_i;
            state_d  = ST_DRAIN;
          end else begin
            cc_d = n_new;
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          rem_d   = rem_next;
          total_d = total_next;
          if (csum_w == 3'd4) begin
            // A full nibble is the last word of this column unless more full nibbles follow or the set ends.
            ovalid_d = 1'b1;
            ohex_d   = a_w;
            ostat_d  = 1'b0;
            osetv_d  = valid_q;
            olast_d  = !setend_q && (32'(total_next) < 32'd4);
            acc_d    = 3'd0;
            cnt_d    = 2'd0;
          end else begin
            acc_d = a_w[2:0];
            cnt_d = csum_w[1:0];
          end
          if (total_next == '0) begin
            par_d = (pdx_w == d_eff) ? '0 : DW'(pdx_w);
            if (!setend_q) begin
              state_d = ST_IDLE;
            end else if (csum_w == 3'd4 || csum_w == 3'd0) begin
              state_d = ST_STATUS;
            end else begin
              state_d = ST_PAD;
            end
          end else if (rem_next == '0) begin
            disk_d = nd_w;
            rem_d  = n_q;
          end
        end
      end
      ST_PAD: begin
        if (out_free) begin
          // Leftover bits of the set go out left-aligned with zero fill.
          ovalid_d = 1'b1;
          ohex_d   = 4'({1'b0, acc_q} << (3'd4 - 3'(cnt_q)));
          ostat_d  = 1'b0;
          osetv_d  = valid_q;
          olast_d  = 1'b0;
          state_d  = ST_STATUS;
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ohex_d   = 4'd0;
          ostat_d  = 1'b1;
          osetv_d  = valid_q;
          olast_d  = 1'b1;
          // The set is over: the stream starts from scratch, registers are kept.
          valid_d  = 1'b1;
          par_d    = '0;
          acc_d    = 3'd0;
          cnt_d    = 2'd0;
          cc_d     = '0;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ndisk_q  <= 4'd2;
      sbits_q  <= 6'd1;
      odd_q    <= 1'b0;
      state_q  <= ST_IDLE;
      cc_q     <= '0;
      par_q    <= '0;
      acc_q    <= 3'd0;
      cnt_q    <= 2'd0;
      valid_q  <= 1'b1;
      disk_q   <= '0;
      pd_q     <= '0;
      n_q      <= '0;
      rem_q    <= '0;
      total_q  <= '0;
      setend_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_NUM_DISKS:   ndisk_q <= cfg_data_i[3:0];
          CFG_SECTOR_BITS: sbits_q <= cfg_data_i;
          CFG_ODD_PARITY:  odd_q   <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      state_q  <= state_d;
      cc_q     <= cc_d;
      par_q    <= par_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      valid_q  <= valid_d;
      disk_q   <= disk_d;
      pd_q     <= pd_d;
      n_q      <= n_d;
      rem_q    <= rem_d;
      total_q  <= total_d;
      setend_q <= setend_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Output payload needs no reset; it is qualified by the valid flag.
  always_ff @(posedge clk_i) begin
    ohex_q  <= ohex_d;
    ostat_q <= ostat_d;
    osetv_q <= osetv_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign hex_digit_o = ohex_q;
  assign is_status_o = ostat_q;
  assign set_valid_o = osetv_q;
  assign last_o      = olast_q;

`ifndef SYNTHESIS
  // A block in drain always has bits left to emit.
  a_drain_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (total_q != '0))
    else $error("drain running with no bits left");

  // The end of a set always leads into the drain and status sequence.
  a_set_end_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && set_end_i) |=> (state_q == ST_DRAIN))
    else $error("set end did not start a drain");

  // A status word always closes its column.
  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_status_o) |-> last_o)
    else $error("status word without last");

  // After the status word goes out the stream state is back to its start.
  a_status_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_STATUS) && out_free) |=> (valid_q && (par_q == '0) && (cnt_q == 2'd0)))
    else $error("stream state not cleared after status");
`endif

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for raid_parity_check_repair: column words go in, hex digit words
// and set status words come out. Depends on rcr_pkg and the block's RTL only.
module tb;
  import rcr_pkg::*;

  localparam int SETTLE_CYCLES = 100;  // settling wait for a block end drain that shows no result

  typedef struct {
    logic [7:0] bits;
    logic [7:0] miss;
    logic       blk_end;
    logic       set_end;
  } col_t;

  typedef struct {
    logic [3:0] hex;
    logic       status;
    logic       valid;
    logic       last;
  } digit_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = 2'd0;
  logic [5:0] cfg_data = 6'd0;
  logic       in_valid = 1'b0;
  logic [7:0] col_bits = 8'd0;
  logic [7:0] miss_mask = 8'd0;
  logic       blk_end = 1'b0;
  logic       set_end = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall_o, out_valid_o, is_status_o, set_valid_o, last_o;
  logic [3:0] hex_digit_o;

  raid_parity_check_repair DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall_o),
    .column_bits_i (col_bits),
    .missing_mask_i(miss_mask),
    .block_end_i   (blk_end),
    .set_end_i     (set_end),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall),
    .hex_digit_o   (hex_digit_o),
    .is_status_o   (is_status_o),
    .set_valid_o   (set_valid_o),
    .last_o        (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Shadow of the configuration registers, raw as written.
  int cfg_disks = 2;
  int cfg_sector = 1;
  logic cfg_odd = 1'b0;

  // Predicted block state.
  logic [7:0] blk_mem [DEF_MAX_SECTOR_BITS];
  int         col_cnt = 0;
  int         par_disk = 0;
  logic [2:0] carry_b = 3'd0;
  int         carry_n = 0;
  logic       vflag = 1'b1;

  col_t   pend_q[$];    // columns still to be offered
  digit_t digit_q[$];   // digit and status words still to arrive

  int  err_cnt = 0;
  int  res_cnt = 0;
  int  cols_done = 0;
  int  sets_done = 0;
  int  settings = 0;
  int  rand_items = 0;
  bit  rand_phase = 1'b0;
  bit  col_taken = 1'b0;

  function automatic int eff_disks();
    if (cfg_disks < 2) return 2;
    if (cfg_disks > DEF_MAX_DISKS) return DEF_MAX_DISKS;
    return cfg_disks;
  endfunction

  function automatic int eff_sector();
    if (cfg_sector == 0 || cfg_sector > DEF_MAX_SECTOR_BITS) return DEF_MAX_SECTOR_BITS;
    return cfg_sector;
  endfunction

  function automatic void push_digit(logic [3:0] h, logic st);
    digit_t r;
    r.hex = h;
    r.status = st;
    r.valid = vflag;
    r.last = 1'b0;
    digit_q.push_back(r);
  endfunction

  // Checks and rebuilds one column, stores it, and on a block end dumps the data disks
  // disk-major into nibbles. The set end pads a partial nibble and adds the status word.
  function automatic void column_to_digits(col_t c);
    int         d, s, nmiss, pd, cnt, first, j, k;
    logic [8:0] wide;
    logic [7:0] dmask, bits, miss, colv;
    logic       par;
    logic [3:0] acc;
    digit_t     r;
    d = eff_disks();
    s = eff_sector();
    wide = (9'd1 << d) - 9'd1;
    dmask = wide[7:0];
    bits = c.bits & dmask;
    miss = c.miss & dmask;
    par = 1'b0;
    nmiss = 0;
    for (j = 0; j < d; j++) begin
      if (miss[j]) nmiss++;
      else par ^= bits[j];
    end
    colv = bits & ~miss;
    if (nmiss >= 2) begin
      vflag = 1'b0;
    end else if (nmiss == 0) begin
      if (par != cfg_odd) vflag = 1'b0;
    end else if (par ^ cfg_odd) begin
      colv |= miss;
    end
    if (col_cnt < DEF_MAX_SECTOR_BITS) begin
      blk_mem[col_cnt] = colv;
      col_cnt++;
    end
    first = digit_q.size();
    if (c.blk_end || c.set_end || col_cnt >= s) begin
      pd = par_disk % d;
      acc = {1'b0, carry_b};
      cnt = carry_n;
      for (j = 0; j < d; j++) begin
        if (j != pd) begin
          for (k = 0; k < col_cnt; k++) begin
            acc = {acc[2:0], blk_mem[k][j]};
            cnt++;
            if (cnt == 4) begin
              push_digit(acc, 1'b0);
              acc = 4'd0;
              cnt = 0;
            end
          end
        end
      end
      carry_b = acc[2:0];
      carry_n = cnt;
      col_cnt = 0;
      par_disk = (pd + 1) % d;
    end
    if (c.set_end) begin
      if (carry_n > 0) push_digit(4'({1'b0, carry_b} << (4 - carry_n)), 1'b0);
      push_digit(4'd0, 1'b1);
      col_cnt = 0;
      par_disk = 0;
      carry_b = 3'd0;
      carry_n = 0;
      vflag = 1'b1;
    end
    if (digit_q.size() > first) begin
      r = digit_q.pop_back();
      r.last = 1'b1;
      digit_q.push_back(r);
    end
  endfunction

  // Random column for d disks; most columns have correct parity once present bits are known.
  function automatic col_t make_column(int d);
    col_t       c;
    logic [8:0] wide;
    logic [7:0] dmask;
    int         r;
    wide = (9'd1 << d) - 9'd1;
    dmask = wide[7:0];
    c.bits = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 65) c.miss = 8'd0;
    else if (r < 85) c.miss = 8'(1 << $urandom_range(0, d - 1));
    else if (r < 92) c.miss = 8'($urandom_range(0, 255)) & ~dmask;
    else c.miss = 8'($urandom_range(0, 255));
    if ((c.miss & dmask) == 8'd0 && $urandom_range(0, 9) != 0 &&
        (^(c.bits & dmask)) != cfg_odd) begin
      c.bits[$urandom_range(0, d - 1)] ^= 1'b1;
    end
    c.blk_end = 1'b0;
    c.set_end = 1'b0;
    return c;
  endfunction

  function automatic void push_col(logic [7:0] b, logic [7:0] m, logic be, logic se);
    col_t c;
    c.bits = b;
    c.miss = m;
    c.blk_end = be;
    c.set_end = se;
    pend_q.push_back(c);
  endfunction

  // Queues nblocks blocks of random columns; with close the last column ends the set.
  // Without close the sequence still stops on a block boundary.
  function automatic void queue_blocks(int nblocks, bit close);
    int   s, d, len, b, k;
    col_t c;
    s = eff_sector();
    d = eff_disks();
    for (b = 0; b < nblocks; b++) begin
      len = s;
      if ($urandom_range(0, 4) == 0 || (s > 8 && $urandom_range(0, 1) == 0))
        len = $urandom_range(1, s);
      for (k = 0; k < len; k++) begin
        c = make_column(d);
        if (k == len - 1) begin
          // A full block may rely on the column count alone to end it.
          c.blk_end = (len < s) ? 1'b1 : ($urandom_range(0, 3) != 0);
          if (close && b == nblocks - 1) begin
            c.set_end = 1'b1;
            c.blk_end = 1'($urandom_range(0, 1));
          end
        end else if ($urandom_range(0, 32) == 0) begin
          c.blk_end = 1'b1;
        end
        pend_q.push_back(c);
        rand_items++;
      end
    end
  endfunction

  task automatic write_reg(cfg_idx_e idx, int val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= 6'(val);
    case (idx)
      CFG_NUM_DISKS:   cfg_disks = val & 15;
      CFG_SECTOR_BITS: cfg_sector = val & 63;
      CFG_ODD_PARITY:  cfg_odd = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int nd, int sb, int op);
    write_reg(CFG_NUM_DISKS, nd);
    write_reg(CFG_SECTOR_BITS, sb);
    write_reg(CFG_ODD_PARITY, op);
    settings++;
  endtask

  // Waits until every queued column is taken and every word has come,
  // then lets a drain that shows no result finish.
  task automatic wait_idle();
    while (pend_q.size() != 0 || in_valid || digit_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Column sender: acceptance and prediction at the rising edge.
  always @(posedge clk_i) begin
    col_taken = 1'b0;
    if (rst_ni && in_valid && !in_stall_o) begin
      column_to_digits('{col_bits, miss_mask, blk_end, set_end});
      col_taken = 1'b1;
      cols_done++;
      if (set_end) sets_done++;
    end
  end

  // Column sender: bursts of words with random gaps, driven at the falling edge.
  int   burst_left = 1;
  int   gap_left = 0;
  col_t nxt;
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || col_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        nxt = pend_q.pop_front();
        in_valid <= 1'b1;
        col_bits <= nxt.bits;
        miss_mask <= nxt.miss;
        blk_end <= nxt.blk_end;
        set_end <= nxt.set_end;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls in segments of varying density, and once holds off for a
  // long stretch while columns are still waiting so that the block backs up.
  int hold_left = 0;
  bit hold_done = 1'b0;
  int seg_left = 0;
  int stall_pct = 0;
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && rand_phase && pend_q.size() >= 8) begin
      hold_done = 1'b1;
      hold_left = 299;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 50);
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 20;
          default: stall_pct = 60;
        endcase
      end
      seg_left--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  digit_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      if (digit_q.size() == 0) begin
        $error("unexpected word: hex_digit %0d is_status %0d", hex_digit_o, is_status_o);
        err_cnt++;
      end else begin
        want = digit_q.pop_front();
        check_field("hex_digit", int'(want.hex), int'(hex_digit_o));
        check_field("is_status", int'(want.status), int'(is_status_o));
        check_field("set_valid", int'(want.valid), int'(set_valid_o));
        check_field("last", int'(want.last), int'(last_o));
        res_cnt++;
      end
    end
  end

  initial begin : main
    int nd, sb, r, nsets, i;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Four disks: high column and mask bits ignored, a rebuild to 0 and to 1, a block
    // ended by the count alone, an early block end after a double miss, padding at set end.
    set_regs(4, 4, 0);
    push_col(8'h00, 8'h00, 1'b0, 1'b0);
    push_col(8'hFF, 8'h00, 1'b0, 1'b0);
    push_col(8'h03, 8'h04, 1'b0, 1'b0);
    push_col(8'h01, 8'h08, 1'b0, 1'b0);
    push_col(8'h05, 8'h03, 1'b1, 1'b0);
    push_col(8'h0F, 8'hF0, 1'b0, 1'b1);
    wait_idle();

    // Disk count above the maximum, sector size zero, odd parity, a parity failure.
    set_regs(12, 0, 1);
    push_col(8'h80, 8'h00, 1'b1, 1'b0);
    push_col(8'h00, 8'h00, 1'b1, 1'b0);
    push_col(8'h7F, 8'h80, 1'b0, 1'b1);
    wait_idle();

    // Rotate the parity disk to 6 with eight disks, then drop to five mid-set.
    set_regs(8, 2, 0);
    push_col(8'h00, 8'h00, 1'b1, 1'b0);
    push_col(8'h03, 8'h00, 1'b1, 1'b0);
    push_col(8'h81, 8'h00, 1'b1, 1'b0);
    push_col(8'hFF, 8'h00, 1'b1, 1'b0);
    push_col(8'h18, 8'h00, 1'b1, 1'b0);
    push_col(8'h66, 8'h00, 1'b1, 1'b0);
    wait_idle();
    set_regs(5, 2, 0);
    push_col(8'h05, 8'h00, 1'b0, 1'b0);
    push_col(8'h1B, 8'h00, 1'b1, 1'b0);
    push_col(8'h11, 8'h00, 1'b0, 1'b1);
    wait_idle();

    // Disk count below two and sector size above the maximum.
    set_regs(1, 40, 1);
    push_col(8'h02, 8'h00, 1'b0, 1'b0);
    push_col(8'h01, 8'h02, 1'b0, 1'b1);
    wait_idle();

    // Random phase; the first one is long enough for the receiver's long hold-off.
    rand_phase = 1'b1;
    set_regs(8, 6, $urandom_range(0, 1));
    queue_blocks(3, 1'b1);
    queue_blocks(3, 1'b1);
    wait_idle();
    while (rand_items < 145) begin
      r = $urandom_range(0, 99);
      nd = (r < 80) ? $urandom_range(2, 8) : $urandom_range(0, 15);
      r = $urandom_range(0, 99);
      if (r < 70) sb = $urandom_range(1, 8);
      else if (r < 85) sb = $urandom_range(9, 31);
      else if (r < 92) sb = 32;
      else sb = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(33, 63);
      set_regs(nd, sb, $urandom_range(0, 1));
      nsets = (eff_sector() > 8) ? 1 : $urandom_range(1, 3);
      for (i = 0; i < nsets; i++)
        queue_blocks((eff_sector() > 8) ? $urandom_range(1, 2) : $urandom_range(1, 4),
                     (i < nsets - 1) || ($urandom_range(0, 4) != 0));
      wait_idle();
    end

    $display("Checked %0d words from %0d columns in %0d finished disk sets,", res_cnt,
             cols_done, sets_done);
    $display("over %0d register settings with random gaps and receiver stalls.", settings);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
rtl/core/rcr_pkg.sv
rtl/core/rcr_lane.sv
rtl/core/rcr_merge.sv
rtl/core/raid_parity_check_repair.sv
test/tb.sv
